// ----- rtl/ccm_pkg.sv -----
package ccm_pkg;

	localparam int TIME_W      = 32;
	localparam int GAP_W       = 16;
	localparam int IDLE_W      = 20;
	localparam int SLEEP_W     = 32;
	localparam int CFG_W       = 32;
	localparam int CFG_IDX_W   = 2;
	localparam int RPM_W       = 24;
	localparam int CRANK_W     = 16;
	localparam int REVS_W      = 32;
	localparam int PEND_W      = 8;
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 80;

	// divider: 42-bit dividend covers interval * 1024
	localparam int CRANK_SHIFT = 10;
	localparam int DIV_N_W     = TIME_W + CRANK_SHIFT;
	localparam int DIV_D_W     = TIME_W;

	localparam logic [TIME_W-1:0]  RPM_SCALE = 32'd15360000; // 60000 * 256
	localparam logic [DIV_D_W-1:0] MS_PER_S  = 32'd1000;
	localparam logic [RPM_W-1:0]   RPM_MAX   = 24'hFFFFFF;

	localparam logic [GAP_W-1:0]   GAP_RST   = 16'd200;
	localparam logic [IDLE_W-1:0]  IDLE_RST  = 20'd3000;
	localparam logic [SLEEP_W-1:0] SLEEP_RST = 32'd600000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MIN_GAP = 2'd0,
		CFG_IDLE    = 2'd1,
		CFG_SLEEP   = 2'd2
	} cfg_idx_t;

	typedef enum logic {
		CMD_PULSE  = 1'b0,
		CMD_SAMPLE = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_DIV_RPM,
		ST_DIV_CRANK,
		ST_OUT
	} state_t;

endpackage

// ----- rtl/crank_cadence_meter.sv -----
// Path: a pulse, or a sample needing no division, passes ST_EVAL and ST_OUT; a cadence
// decay adds ST_DIV_RPM, and pending revolutions add ST_DIV_RPM and ST_DIV_CRANK.
// Throughput: one item at a time; next input taken once the result is registered.
// The shared bit-serial divider (42 steps per division) sets the sample time.
// Reset (arst_n low, asynchronous): tracking state zero, regs to 200 / 3000 / 600000.
module crank_cadence_meter (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [ccm_pkg::IN_TDATA_W-1:0]     s_tdata,  // [31:0] time_ms
	input  logic                               s_tuser,  // [0] command
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [23:0] rpm_q8, [39:24] crank_time_1024, [71:40] total_revs, [72] sleep_due
	output logic [ccm_pkg::OUT_TDATA_W-1:0]    m_tdata,
	input  logic                               cfg_we,
	input  logic [ccm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ccm_pkg::CFG_W-1:0]          cfg_data
);

	localparam int TW = ccm_pkg::TIME_W;

	ccm_pkg::state_t state_q, state_d;

	logic [ccm_pkg::GAP_W-1:0]   gap_q;
	logic [ccm_pkg::IDLE_W-1:0]  idle_q;
	logic [ccm_pkg::SLEEP_W-1:0] sleep_q;

	logic [TW-1:0]               acc_pulse_q;
	logic [TW-1:0]               last_event_q;
	logic [ccm_pkg::PEND_W-1:0]  pending_q;
	logic [ccm_pkg::REVS_W-1:0]  total_q;
	logic [TW-1:0]               sample_time_q;
	logic [TW-1:0]               prev_int_q;
	logic [ccm_pkg::RPM_W-1:0]   cadence_q;
	logic [ccm_pkg::CRANK_W-1:0] crank_q;
	logic                        crank_due_q;

	ccm_pkg::cmd_t               cmd_q;
	logic [TW-1:0]               now_q;
	logic [TW-1:0]               interval_q;

	logic                        m_tvalid_q;
	logic [ccm_pkg::OUT_TDATA_W-1:0] m_tdata_q;

	logic [TW-1:0]               interval;
	logic [TW-1:0]               pulse_gap;
	logic                        pulse_ok;
	logic                        smp_ok;
	logic                        idle_exp;
	logic                        decay;
	logic                        have_revs;
	logic [ccm_pkg::PEND_W-1:0]  revs_sel;
	logic [TW-1:0]               rpm_num;
	logic                        sleep_bit;
	logic                        out_load;

	logic                        div_start;
	logic [ccm_pkg::DIV_N_W-1:0] div_dividend;
	logic [ccm_pkg::DIV_D_W-1:0] div_divisor;
	logic                        div_done;
	logic [ccm_pkg::DIV_N_W-1:0] div_quo;
	logic [ccm_pkg::RPM_W-1:0]   rpm_sat;

	always_comb begin
		interval  = now_q - sample_time_q;
		pulse_gap = now_q - acc_pulse_q;
		pulse_ok  = pulse_gap > {{(TW-ccm_pkg::GAP_W){1'b0}}, gap_q};
		smp_ok    = interval > {{(TW-ccm_pkg::GAP_W){1'b0}}, gap_q};
		idle_exp  = interval > {{(TW-ccm_pkg::IDLE_W){1'b0}}, idle_q};
		decay     = (cadence_q != '0) && (prev_int_q != '0) && (interval > prev_int_q);
		have_revs = pending_q != '0;
		revs_sel  = have_revs ? pending_q : ccm_pkg::PEND_W'(1);
		rpm_num   = TW'(ccm_pkg::RPM_SCALE * {{(TW-ccm_pkg::PEND_W){1'b0}}, revs_sel});
		sleep_bit = (now_q - last_event_q) > ccm_pkg::SLEEP_W'(sleep_q);
		rpm_sat   = (|div_quo[ccm_pkg::DIV_N_W-1:ccm_pkg::RPM_W]) ? ccm_pkg::RPM_MAX
			: div_quo[ccm_pkg::RPM_W-1:0];
	end

	always_comb begin
		state_d      = state_q;
		div_start    = 1'b0;
		div_dividend = {{ccm_pkg::CRANK_SHIFT{1'b0}}, rpm_num};
		div_divisor  = interval;
		out_load     = 1'b0;
		case (state_q)
			ccm_pkg::ST_IDLE: begin
				if (s_tvalid) state_d = ccm_pkg::ST_EVAL;
			end
			ccm_pkg::ST_EVAL: begin
				if (cmd_q == ccm_pkg::CMD_SAMPLE && smp_ok &&
				    (have_revs || (!idle_exp && decay))) begin
					div_start = 1'b1;
					state_d   = ccm_pkg::ST_DIV_RPM;
				end else begin
					state_d = ccm_pkg::ST_OUT;
				end
			end
			ccm_pkg::ST_DIV_RPM: begin
				if (div_done) begin
					if (crank_due_q) begin
						div_start    = 1'b1;
						div_dividend = {interval_q, {ccm_pkg::CRANK_SHIFT{1'b0}}};
						div_divisor  = ccm_pkg::MS_PER_S;
						state_d      = ccm_pkg::ST_DIV_CRANK;
					end else begin
						state_d = ccm_pkg::ST_OUT;
					end
				end
			end
			ccm_pkg::ST_DIV_CRANK: begin
				if (div_done) state_d = ccm_pkg::ST_OUT;
			end
			ccm_pkg::ST_OUT: begin
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = ccm_pkg::ST_IDLE;
				end
			end
			default: state_d = ccm_pkg::ST_IDLE;
		endcase
	end

	assign s_tready = state_q == ccm_pkg::ST_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ccm_pkg::ST_IDLE;
			gap_q         <= ccm_pkg::GAP_RST;
			idle_q        <= ccm_pkg::IDLE_RST;
			sleep_q       <= ccm_pkg::SLEEP_RST;
			acc_pulse_q   <= '0;
			last_event_q  <= '0;
			pending_q     <= '0;
			total_q       <= '0;
			sample_time_q <= '0;
			prev_int_q    <= '0;
			cadence_q     <= '0;
			crank_q       <= '0;
			crank_due_q   <= 1'b0;
			m_tvalid_q    <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_we) begin
				case (cfg_index)
					ccm_pkg::CFG_MIN_GAP: gap_q   <= cfg_data[ccm_pkg::GAP_W-1:0];
					ccm_pkg::CFG_IDLE:    idle_q  <= cfg_data[ccm_pkg::IDLE_W-1:0];
					ccm_pkg::CFG_SLEEP:   sleep_q <= cfg_data[ccm_pkg::SLEEP_W-1:0];
					default: ;
				endcase
			end

			if (state_q == ccm_pkg::ST_EVAL) begin
				crank_due_q <= 1'b0;
				if (cmd_q == ccm_pkg::CMD_PULSE) begin
					last_event_q <= now_q;
					if (pulse_ok) begin
						pending_q   <= pending_q + 1'b1;
						total_q     <= total_q + 1'b1;
						acc_pulse_q <= now_q;
					end
				end else if (smp_ok) begin
					if (!have_revs) begin
						if (idle_exp) cadence_q <= '0;
					end else begin
						pending_q     <= '0;
						sample_time_q <= now_q;
						prev_int_q    <= interval;
						crank_due_q   <= 1'b1;
					end
				end
			end

			if (state_q == ccm_pkg::ST_DIV_RPM && div_done) cadence_q <= rpm_sat;
			if (state_q == ccm_pkg::ST_DIV_CRANK && div_done)
				crank_q <= crank_q + div_quo[ccm_pkg::CRANK_W-1:0];

			if (out_load) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_q <= ccm_pkg::cmd_t'(s_tuser);
			now_q <= s_tdata[TW-1:0];
		end
		if (state_q == ccm_pkg::ST_EVAL) interval_q <= interval;
		if (out_load) begin
			m_tdata_q <= {7'b0, sleep_bit, total_q, crank_q, cadence_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	ccm_div #(
		.N_W(ccm_pkg::DIV_N_W),
		.D_W(ccm_pkg::DIV_D_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

endmodule

// ----- rtl/ccm_div.sv -----
module ccm_div #(
	parameter int N_W = ccm_pkg::DIV_N_W,
	parameter int D_W = ccm_pkg::DIV_D_W
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [N_W-1:0] dividend,
	input  logic [D_W-1:0] divisor,
	output logic           done,
	output logic [N_W-1:0] quotient
);

	localparam int CNT_W = $clog2(N_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [D_W-1:0]   rem_q;
	logic [N_W-1:0]   quo_q;
	logic [D_W-1:0]   den_q;

	logic [D_W:0]     shifted;
	logic [D_W:0]     diff;
	logic             ge;
	logic [D_W-1:0]   rem_nx;

	// restoring division, one quotient bit per cycle
	always_comb begin
		shifted = {rem_q, quo_q[N_W-1]};
		ge      = shifted >= {1'b0, den_q};
		diff    = shifted - {1'b0, den_q};
		rem_nx  = ge ? diff[D_W-1:0] : shifted[D_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(N_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			quo_q <= {quo_q[N_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- rtl/ccm_checker.sv -----
module ccm_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [ccm_pkg::OUT_TDATA_W-1:0] m_tdata
);

	// one transaction in flight: ready drops right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted twice in a row");

	// a new result is raised only while the input side is busy
	a_out_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result raised without a transaction in flight");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result changed while stalled");

endmodule

bind crank_cadence_meter ccm_checker u_ccm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ----- tb/tb.sv -----
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ccm_pkg::*;

	localparam int      CYCLE_LIMIT = 4000000;
	localparam int      SETTLE      = 120;
	localparam int      SHOW_MAX    = 10;

	typedef struct {
		logic [RPM_W-1:0]   rpm;
		logic [CRANK_W-1:0] crank;
		logic [REVS_W-1:0]  revs;
		logic               sleep;
	} reading_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;  // [31:0] time_ms
	logic                   s_tuser;  // [0] command
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;  // [23:0] rpm, [39:24] crank, [71:40] revs, [72] sleep
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_W-1:0]       cfg_data;

	crank_cadence_meter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// cadence model: registers and state
	logic [31:0]      gap_cfg;
	logic [31:0]      idle_cfg;
	logic [31:0]      sleep_cfg;
	logic [31:0]      pulse_ok_t;
	logic [31:0]      last_evt_t;
	logic [PEND_W-1:0] pend_cnt;
	logic [31:0]      rev_count;
	logic [31:0]      smp_t;
	logic [31:0]      prev_ivl;
	logic [RPM_W-1:0] cadence;
	logic [15:0]      crank_ts;

	reading_t expected_readings[$];
	int       mismatches;
	int       cycles;
	bit       pace_on;
	int       sink_hold;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic logic [RPM_W-1:0] cadence_q8(logic [31:0] revs, logic [31:0] ivl);
		logic [63:0] q;
		if (ivl == 0)
			return '0;
		q = (64'd15360000 * {32'd0, revs}) / {32'd0, ivl};
		return (q > {40'd0, RPM_MAX}) ? RPM_MAX : q[RPM_W-1:0];
	endfunction

	task automatic predict_reading(cmd_t cmd, logic [31:0] now);
		logic [31:0] ivl;
		logic [63:0] adv;
		reading_t    r;
		if (cmd == CMD_PULSE) begin
			last_evt_t = now;
			if (now - pulse_ok_t > gap_cfg) begin
				pend_cnt   = pend_cnt + 1'b1;
				rev_count  = rev_count + 1;
				pulse_ok_t = now;
			end
		end else begin
			ivl = now - smp_t;
			if (ivl > gap_cfg) begin
				if (pend_cnt == 0) begin
					if (ivl > idle_cfg)
						cadence = '0;
					else if (cadence > 0 && prev_ivl > 0 && ivl > prev_ivl)
						cadence = cadence_q8(32'd1, ivl);
				end else begin
					cadence  = cadence_q8({24'd0, pend_cnt}, ivl);
					pend_cnt = '0;
					smp_t    = now;
					prev_ivl = ivl;
					adv      = ({32'd0, ivl} * 64'd1024) / 64'd1000;
					crank_ts = crank_ts + adv[15:0];
				end
			end
		end
		r.rpm   = cadence;
		r.crank = crank_ts;
		r.revs  = rev_count;
		r.sleep = ((now - last_evt_t) > sleep_cfg);
		expected_readings.push_back(r);
	endtask

	task automatic report_error(string what, logic [31:0] want, logic [31:0] got);
		mismatches++;
		if (mismatches <= SHOW_MAX)
			$display("mismatch %0s: expected %0h, got %0h", what, want, got);
	endtask

	always @(posedge clk) begin : check_results
		reading_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_readings.size() == 0) begin
				report_error("unexpected transaction", 32'd0, m_tdata[31:0]);
			end else begin
				want = expected_readings.pop_front();
				if (m_tdata[23:0] !== want.rpm)
					report_error("rpm_q8", want.rpm, m_tdata[23:0]);
				if (m_tdata[39:24] !== want.crank)
					report_error("crank_time_1024", want.crank, m_tdata[39:24]);
				if (m_tdata[71:40] !== want.revs)
					report_error("total_revs", want.revs, m_tdata[71:40]);
				if (m_tdata[72] !== want.sleep)
					report_error("sleep_due", want.sleep, m_tdata[72]);
			end
		end
	end

	// output backpressure in bursts
	always @(negedge clk) begin
		if (sink_hold > 0) begin
			sink_hold--;
			m_tready = 1'b0;
		end else if (pace_on && $urandom_range(0, 5) == 0) begin
			sink_hold = $urandom_range(0, 14);
			m_tready  = 1'b0;
		end else begin
			m_tready = 1'b1;
		end
	end

	// called and returns at a falling edge
	task automatic send_item(cmd_t cmd, logic [31:0] now);
		if (pace_on && $urandom_range(0, 3) == 0) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = cmd;
		s_tdata  = now;
		do
			@(posedge clk);
		while (!s_tready);
		predict_reading(cmd, now);
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic wait_drained;
		while (expected_readings.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		case (idx)
			CFG_MIN_GAP: gap_cfg   = {16'd0, val[15:0]};
			CFG_IDLE:    idle_cfg  = {12'd0, val[19:0]};
			CFG_SLEEP:   sleep_cfg = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic set_regs(logic [31:0] gap, logic [31:0] idle, logic [31:0] sleep);
		wait_drained();
		write_reg(CFG_MIN_GAP, gap);
		write_reg(CFG_IDLE, idle);
		write_reg(CFG_SLEEP, sleep);
	endtask

	task automatic test_directed;
		send_item(CMD_SAMPLE, 32'd0);
		send_item(CMD_PULSE, 32'd100);        // too close to last accepted pulse
		send_item(CMD_PULSE, 32'd201);
		send_item(CMD_PULSE, 32'd500);
		send_item(CMD_SAMPLE, 32'd1000);      // two revs pending
		send_item(CMD_SAMPLE, 32'd1100);      // too soon
		send_item(CMD_SAMPLE, 32'd1500);      // shorter than last interval, hold
		send_item(CMD_SAMPLE, 32'd2500);      // decay
		send_item(CMD_SAMPLE, 32'd5000);      // idle timeout
		send_item(CMD_SAMPLE, 32'd700000);    // sleep due
		send_item(CMD_PULSE, 32'd700001);
		send_item(CMD_SAMPLE, 32'hFFFF_FFF0);
		send_item(CMD_PULSE, 32'h0000_0100);  // time wraps
		send_item(CMD_SAMPLE, 32'h0000_0200);
	endtask

	task automatic test_register_extremes;
		set_regs(32'd0, 32'd0, 32'd0);
		send_item(CMD_PULSE, 32'd1000);
		send_item(CMD_SAMPLE, 32'd5000);
		send_item(CMD_PULSE, 32'd5010);
		send_item(CMD_PULSE, 32'd5011);
		send_item(CMD_SAMPLE, 32'd5001);      // two revs over 1 ms saturates
		send_item(CMD_SAMPLE, 32'd5002);
		set_regs(32'd65535, 32'd1048575, 32'hFFFF_FFFF);
		send_item(CMD_PULSE, 32'd70546);
		send_item(CMD_PULSE, 32'd70547);
		send_item(CMD_SAMPLE, 32'd70537);
		send_item(CMD_SAMPLE, 32'd170537);
		send_item(CMD_SAMPLE, 32'hC000_0000);
	endtask

	task automatic test_pending_wrap;
		logic [31:0] t;
		set_regs(32'd0, 32'd3000, 32'd600000);
		t = 32'h4000_0000;
		send_item(CMD_SAMPLE, t);
		for (int i = 1; i <= 256; i++)
			send_item(CMD_PULSE, t + i);
		send_item(CMD_SAMPLE, t + 300);       // count wrapped to zero
		for (int i = 301; i <= 555; i++)
			send_item(CMD_PULSE, t + i);
		send_item(CMD_SAMPLE, t + 700);
	endtask

	task automatic run_ride(int n_items, logic [31:0] t0, bit allow_pace);
		logic [31:0] now;
		logic [31:0] step;
		int          roll;
		cmd_t        cmd;
		now = t0;
		for (int i = 0; i < n_items; i++) begin
			if (i % 40 == 0)
				pace_on = allow_pace && ($urandom_range(0, 3) != 0);
			roll = $urandom_range(0, 99);
			if (roll < 80)
				step = $urandom_range(0, 2 * gap_cfg + 1500);
			else if (roll < 92)
				step = $urandom_range(0, idle_cfg + 4000);
			else if (roll < 96)
				step = (sleep_cfg > 32'h7FFF_FFFF) ? $urandom : $urandom_range(0, 2 * sleep_cfg + 10);
			else if (roll < 98)
				step = $urandom;
			else
				step = -$urandom_range(1, 3000);
			now = now + step;
			cmd = ($urandom_range(0, 99) < 60) ? CMD_PULSE : CMD_SAMPLE;
			send_item(cmd, now);
		end
	endtask

	task automatic test_ride_phases;
		set_regs(32'd200, 32'd3000, 32'd600000);
		run_ride(90, $urandom, 1'b1);
		set_regs($urandom_range(0, 1000), $urandom_range(0, 5000), $urandom_range(0, 30000));
		run_ride(90, 32'hFFFF_F000 + $urandom_range(0, 4095), 1'b1);
		set_regs(32'd0, 32'd1048575, 32'd0);
		run_ride(90, $urandom, 1'b1);
		set_regs(32'd65535, 32'd0, 32'hFFFF_FFFF);
		run_ride(90, $urandom, 1'b1);
		set_regs($urandom_range(0, 1000), $urandom_range(0, 1048575), $urandom);
		run_ride(90, $urandom, 1'b1);
	endtask

	task automatic test_full_rate;
		set_regs(32'd200, 32'd3000, 32'd600000);
		run_ride(100, $urandom, 1'b0);
	endtask

	initial begin
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = CMD_PULSE;
		m_tready   = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = CFG_MIN_GAP;
		cfg_data   = '0;
		cycles     = 0;
		mismatches = 0;
		sink_hold  = 0;
		pace_on    = 1'b1;
		gap_cfg    = 32'd200;
		idle_cfg   = 32'd3000;
		sleep_cfg  = 32'd600000;
		pulse_ok_t = '0;
		last_evt_t = '0;
		pend_cnt   = '0;
		rev_count  = '0;
		smp_t      = '0;
		prev_ivl   = '0;
		cadence    = '0;
		crank_ts   = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_register_extremes();
		test_pending_wrap();
		test_ride_phases();
		test_full_rate();

		wait_drained();
		if (mismatches == 0 && expected_readings.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
